[rtl/core/md5_pkg.sv]
`default_nettype none

package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
  } md5_out_t;

  // Write request into the message block buffer: bits set in keep preserve
  // the matching byte lanes of the old word, the rest come from data.
  typedef struct packed {
    logic        en;
    logic [3:0]  idx;
    logic [3:0]  keep;
    logic [31:0] data;
  } md5_wr_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] PAD_BYTE = 32'h0000_0080;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam logic [4:0] ROUND_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a given round.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] g;
    r = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = r;
      2'd1:    g = r * 4'd5 + 4'd1;
      2'd2:    g = r * 4'd3 + 4'd5;
      default: g = r * 4'd7;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[rtl/core/md5_block_buf.sv]
`default_nettype none

module md5_block_buf (
  input  wire logic             clk,
  input  wire md5_pkg::md5_wr_t wr,
  input  wire logic [3:0]       ridx,
  output logic [31:0]           rdata
);
  import md5_pkg::*;

  logic [31:0] words [16];
  logic [31:0] keep_mask;

  // Widen the per-lane keep flags to a bit mask.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      keep_mask[i*8 +: 8] = {8{wr.keep[i]}};
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      words[wr.idx] <= (words[wr.idx] & keep_mask) | (wr.data & ~keep_mask);
    end
  end

  // Registered read: the address is presented in the cycle before the data is used.
  always_ff @(posedge clk) begin
    rdata <= words[ridx];
  end

endmodule

`default_nettype wire

[rtl/core/md5_round.sv]
`default_nettype none

module md5_round (
  input  wire logic [5:0]  rnd,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic [31:0] c,
  input  wire logic [31:0] d,
  input  wire logic [31:0] m,
  output logic [31:0]      b_next
);
  import md5_pkg::*;

  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] rot;
  logic [4:0]  s;

  always_comb begin
    case (rnd[5:4])
      2'd0:    f = d ^ (b & (c ^ d));
      2'd1:    f = c ^ (d & (b ^ c));
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
  end

  assign s   = ROUND_S[{rnd[5:4], rnd[1:0]}];
  assign sum = a + f + ROUND_K[rnd] + m;
  // Shift amounts are never zero, so the right shift stays below 32.
  assign rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  assign b_next = b + rot;

endmodule

`default_nettype wire

[rtl/core/md5_message_digest.sv]
`default_nettype none

// MD5 digest engine fed one message byte per transaction. A plain byte is
// taken without leaving the idle state, so bytes stream at one per clock
// until a 64-byte block fills; the block then runs through a single shared
// round unit at one round per cycle, followed by a fold into the chaining
// words, and input stays stalled throughout. A transaction with last_byte
// set starts padding: the 0x80 marker is written, each remaining block word
// (up to 15) is zeroed or given the bit length, the working registers are
// loaded, then the block is compressed. When the marker lands at byte 56 or
// later, a second fill of all 16 words, its load and a second compression
// follow. The digest is then placed in an output register and the engine
// returns to the initial chaining values; the next message may start while
// the digest waits to be taken. Transactions with neither a byte nor a last
// mark are accepted and dropped. The bit length wraps modulo 2^64.
module md5_message_digest (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire md5_pkg::md5_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output md5_pkg::md5_out_t      out_data
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_HEAD,
    ST_PAD_FILL,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  state_t      state;
  logic [31:0] chain_a, chain_b, chain_c, chain_d;
  logic [31:0] a, b, c, d;
  logic [5:0]  rnd;
  logic [60:0] byte_count;
  logic [4:0]  fill_idx;
  logic        last_pend;
  logic        padding;
  logic        second;

  logic [5:0]  pos;
  logic        long_pad;
  logic [31:0] fill_word;
  logic [4:0]  lane_sh;
  md5_wr_t     wr;
  logic [3:0]  rd_idx;
  logic [31:0] msg_word;
  logic [31:0] b_next;
  logic        in_take;
  logic        emit_fire;

  assign in_ready  = (state == ST_IDLE);
  assign in_take   = in_valid && in_ready;
  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_ready);
  assign pos       = byte_count[5:0];
  assign lane_sh   = {pos[1:0], 3'b000};
  // Marker at byte 56 or later leaves no room for the length: two blocks.
  assign long_pad  = (pos[5:3] == 3'b111);

  always_comb begin
    if (long_pad && !second) begin
      fill_word = '0;
    end else if (fill_idx[3:0] == 4'd14) begin
      fill_word = {byte_count[28:0], 3'b000};
    end else if (fill_idx[3:0] == 4'd15) begin
      fill_word = byte_count[60:29];
    end else begin
      fill_word = '0;
    end
  end

  // Single write port into the block buffer: absorb a byte, place the
  // padding marker, or sweep the remaining words.
  always_comb begin
    wr = '0;
    case (state)
      ST_IDLE: begin
        if (in_take && in_data.has_byte) begin
          wr.en   = 1'b1;
          wr.idx  = pos[5:2];
          wr.keep = ~(4'b0001 << pos[1:0]);
          wr.data = {24'b0, in_data.data_byte} << lane_sh;
        end
      end
      ST_PAD_HEAD: begin
        wr.en   = 1'b1;
        wr.idx  = pos[5:2];
        wr.keep = (4'b0001 << pos[1:0]) - 4'd1;
        wr.data = PAD_BYTE << lane_sh;
      end
      ST_PAD_FILL: begin
        if (!fill_idx[4]) begin
          wr.en   = 1'b1;
          wr.idx  = fill_idx[3:0];
          wr.keep = '0;
          wr.data = fill_word;
        end
      end
      default: wr = '0;
    endcase
  end

  // Fetch the word for the next round; the load cycle before round 0
  // fetches word 0.
  assign rd_idx = (state == ST_ROUND) ? msg_index(rnd + 6'd1) : 4'd0;

  md5_block_buf u_buf (
    .clk   (clk),
    .wr    (wr),
    .ridx  (rd_idx),
    .rdata (msg_word)
  );

  md5_round u_round (
    .rnd    (rnd),
    .a      (a),
    .b      (b),
    .c      (c),
    .d      (d),
    .m      (msg_word),
    .b_next (b_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      chain_a    <= IV_A;
      chain_b    <= IV_B;
      chain_c    <= IV_C;
      chain_d    <= IV_D;
      byte_count <= '0;
      last_pend  <= 1'b0;
      padding    <= 1'b0;
      second     <= 1'b0;
      out_valid  <= 1'b0;
      rnd        <= '0;
      fill_idx   <= '0;
    end else begin
      // Raise valid for a new digest; drop the held one once taken.
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (in_data.has_byte) begin
              byte_count <= byte_count + 61'd1;
            end
            if (in_data.has_byte && pos == 6'd63) begin
              // Block full: compress it, then pad if this was the end.
              last_pend <= in_data.last_byte;
              a         <= chain_a;
              b         <= chain_b;
              c         <= chain_c;
              d         <= chain_d;
              rnd       <= '0;
              state     <= ST_ROUND;
            end else if (in_data.last_byte) begin
              state <= ST_PAD_HEAD;
            end
          end
        end
        ST_PAD_HEAD: begin
          padding  <= 1'b1;
          second   <= 1'b0;
          fill_idx <= {1'b0, pos[5:2]} + 5'd1;
          state    <= ST_PAD_FILL;
        end
        ST_PAD_FILL: begin
          if (fill_idx[4]) begin
            a     <= chain_a;
            b     <= chain_b;
            c     <= chain_c;
            d     <= chain_d;
            rnd   <= '0;
            state <= ST_ROUND;
          end else begin
            fill_idx <= fill_idx + 5'd1;
          end
        end
        ST_ROUND: begin
          a   <= d;
          b   <= b_next;
          c   <= b;
          d   <= c;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          chain_a <= chain_a + a;
          chain_b <= chain_b + b;
          chain_c <= chain_c + c;
          chain_d <= chain_d + d;
          if (padding) begin
            if (long_pad && !second) begin
              // Length block: clear every word, length lands in 14 and 15.
              second   <= 1'b1;
              fill_idx <= '0;
              state    <= ST_PAD_FILL;
            end else begin
              state <= ST_EMIT;
            end
          end else if (last_pend) begin
            last_pend <= 1'b0;
            state     <= ST_PAD_HEAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          // Hold until the output register is free.
          if (emit_fire) begin
            out_data.digest_a <= chain_a;
            out_data.digest_b <= chain_b;
            out_data.digest_c <= chain_c;
            out_data.digest_d <= chain_d;
            chain_a           <= IV_A;
            chain_b           <= IV_B;
            chain_c           <= IV_C;
            chain_d           <= IV_D;
            byte_count        <= '0;
            padding           <= 1'b0;
            second            <= 1'b0;
            last_pend         <= 1'b0;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[verif/tb_top.sv]
module tb_top;
  import md5_pkg::*;

  // Receiver hold-off used to fill the engine and stall its input
  localparam int unsigned LONG_HOLD_CYCLES = 500;
  // One message can take two fills, two compressions and the output stage
  localparam int unsigned SETTLE_CYCLES    = 200;
  localparam int unsigned DRAIN_LIMIT      = 5000;
  localparam int unsigned RANDOM_ITEMS     = 360;

  // Additive constants and rotate amounts of the four round groups
  localparam logic [31:0] SINE_T [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };
  localparam int unsigned ROT_AMOUNT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  // Digests of the empty message and of "abc", as little-endian words
  localparam md5_out_t EMPTY_DIGEST = '{32'hd98c1dd4, 32'h04b2008f,
                                        32'h980980e9, 32'h7e42f8ec};
  localparam md5_out_t ABC_DIGEST   = '{32'h98500190, 32'hb04fd23c,
                                        32'h7d3f96d6, 32'h727fe128};

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  md5_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  md5_out_t out_data;

  md5_message_digest u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Digest state of the predictor: chaining words, the block being filled
  // and the running byte count of the current message
  logic [31:0] hash_words [4];
  logic [31:0] msg_words  [16];
  logic [60:0] msg_bytes;

  md5_out_t    expected_digests [$];
  int unsigned items_sent       = 0;
  int unsigned digests_seen     = 0;
  int unsigned fail_count       = 0;
  bit          gaps_on          = 1'b1;
  bit          long_hold_req    = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void hash_restart();
    hash_words[0] = 32'h67452301;
    hash_words[1] = 32'hefcdab89;
    hash_words[2] = 32'h98badcfe;
    hash_words[3] = 32'h10325476;
    msg_bytes     = '0;
  endfunction

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Run the 64 rounds over msg_words and fold the result into hash_words
  function automatic void md5_compress_block();
    logic [31:0] a, b, c, d, f, t;
    int unsigned i, g, grp;
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    for (i = 0; i < 64; i++) begin
      grp = i / 16;
      case (grp)
        0: begin
          f = d ^ (b & (c ^ d));
          g = i;
        end
        1: begin
          f = c ^ (d & (b ^ c));
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rol32(a + f + SINE_T[i] + msg_words[g], ROT_AMOUNT[grp * 4 + i % 4]);
      a = t;
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
  endfunction

  // Bytes land little-endian within each block word
  function automatic void store_byte(input int unsigned pos, input logic [7:0] value);
    msg_words[pos[5:2]][pos[1:0] * 8 +: 8] = value;
  endfunction

  // Absorb one transaction; return 1 with the digest when it ends a message
  function automatic bit absorb_item(input md5_in_t item, output md5_out_t digest);
    int unsigned pos, k;
    logic [63:0] bit_len;
    digest = '0;
    if (item.has_byte) begin
      pos = 32'(msg_bytes[5:0]);
      store_byte(pos, item.data_byte);
      msg_bytes = msg_bytes + 61'd1;
      if (pos == 63)
        md5_compress_block();
    end
    if (!item.last_byte)
      return 1'b0;
    // Pad: marker byte, zeros to the end of the block, then the bit length
    pos     = 32'(msg_bytes[5:0]);
    bit_len = {msg_bytes, 3'b000};
    store_byte(pos, 8'h80);
    for (k = pos + 1; k < 64; k++)
      store_byte(k, 8'h00);
    // No room left for the length: spill into a second block
    if (pos >= 56) begin
      md5_compress_block();
      foreach (msg_words[w])
        msg_words[w] = '0;
    end
    msg_words[14] = bit_len[31:0];
    msg_words[15] = bit_len[63:32];
    md5_compress_block();
    digest.digest_a = hash_words[0];
    digest.digest_b = hash_words[1];
    digest.digest_c = hash_words[2];
    digest.digest_d = hash_words[3];
    hash_restart();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: out_ready, with random bursts of idling and the long hold
  // ---------------------------------------------------------------------------

  initial begin : drive_out_ready
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every accepted digest against the oldest expectation
  // ---------------------------------------------------------------------------

  function automatic void compare_word(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_digest
    md5_out_t want;
    if (!rst && out_valid && out_ready) begin
      digests_seen++;
      if (expected_digests.size() == 0) begin
        $display("%0t: unexpected digest: expected none actual %h", $time, out_data);
        fail_count++;
      end else begin
        want = expected_digests.pop_front();
        compare_word("digest_a", want.digest_a, out_data.digest_a);
        compare_word("digest_b", want.digest_b, out_data.digest_b);
        compare_word("digest_c", want.digest_c, out_data.digest_c);
        compare_word("digest_d", want.digest_d, out_data.digest_d);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one transaction and hold it until taken. Valid stays high on
  // return so a following item goes out back to back; an idle burst, if
  // drawn, drops it first.
  task automatic send_item(input logic [7:0] value, input logic has, input logic last);
    md5_in_t  item;
    md5_out_t digest;
    item.data_byte = value;
    item.has_byte  = has;
    item.last_byte = last;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (absorb_item(item, digest))
      expected_digests.push_back(digest);
    if (has || last)
      items_sent++;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Send a message of random bytes. The end comes either on the last byte
  // or as a separate empty marker; noise adds idle transactions in between.
  task automatic send_message(input int unsigned len, input bit mark_apart,
                              input bit noisy);
    int unsigned n;
    for (n = 0; n < len; n++) begin
      if (noisy && $urandom_range(0, 19) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, !mark_apart && (n == len - 1));
    end
    if (mark_apart || len == 0)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Mostly short messages, with many lengths around the one- and two-block
  // padding boundaries (55/56 and 119/120 bytes) and whole blocks
  function automatic int unsigned pick_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 16);
      4, 5, 6:    return $urandom_range(52, 68);
      7:          return $urandom_range(116, 130);
      default:    return $urandom_range(17, 51);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Prove the predictor on two published digests before trusting it
  task automatic test_predictor_known_answers();
    md5_in_t  item;
    md5_out_t digest;
    bit       done;
    hash_restart();
    item = '{data_byte: 8'h00, has_byte: 1'b0, last_byte: 1'b1};
    done = absorb_item(item, digest);
    if (!done || digest !== EMPTY_DIGEST) begin
      $display("%0t: empty message digest: expected %h actual %h", $time,
               EMPTY_DIGEST, digest);
      fail_count++;
    end
    item = '{data_byte: 8'h61, has_byte: 1'b1, last_byte: 1'b0};
    done = absorb_item(item, digest);
    item.data_byte = 8'h62;
    done = absorb_item(item, digest);
    item = '{data_byte: 8'h63, has_byte: 1'b1, last_byte: 1'b1};
    done = absorb_item(item, digest);
    if (!done || digest !== ABC_DIGEST) begin
      $display("%0t: abc digest: expected %h actual %h", $time, ABC_DIGEST, digest);
      fail_count++;
    end
    hash_restart();
  endtask

  // Empty message, byte extremes, idle transactions and the separate end
  // marker, each on its own and mixed into a short message
  task automatic test_directed_items();
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  // Hold the receiver off while short messages keep coming, so the output
  // register fills, the next digest backs up behind it and input stalls
  task automatic test_output_backpressure();
    int unsigned m;
    long_hold_req = 1'b1;
    for (m = 0; m < 6; m++)
      send_message($urandom_range(1, 4), 1'($urandom_range(0, 1)), 1'b0);
  endtask

  task automatic test_random_messages();
    int unsigned start_items;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS)
      send_message(pick_length(), $urandom_range(0, 3) == 0, 1'b1);
  endtask

  // Close with both sides running flat out
  task automatic test_streaming_tail();
    int unsigned m;
    gaps_on = 1'b0;
    for (m = 0; m < 3; m++)
      send_message(pick_length(), m[0], 1'b0);
  endtask

  initial begin : run_tests
    int unsigned n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_predictor_known_answers();
    test_directed_items();
    test_output_backpressure();
    test_random_messages();
    test_streaming_tail();
    in_valid <= 1'b0;

    // Drain outstanding digests, then allow the engine to settle
    n = 0;
    while (expected_digests.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_digests.size() != 0) begin
      $display("%0t: %0d expected digest(s) never arrived", $time,
               expected_digests.size());
      fail_count++;
    end

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
